@@ hdl/limit_order_book_matcher_unit_macros.svh @@
// shared assertion macros for the matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define LOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define LOB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// types and constants shared by the order book matcher
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

    localparam int BOOK_DEPTH = 256;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int VAL_W      = 30;
    localparam logic [VAL_W-1:0] BACKLOG_MOD = 30'd1000000007;

    typedef struct packed {
        logic [VAL_W-1:0] price;
        logic [VAL_W-1:0] amount;
        logic             side;
    } t_order;

    typedef struct packed {
        logic [VAL_W-1:0] filled_amount;
        logic [VAL_W-1:0] rested_amount;
        logic             book_full_drop;
        logic [VAL_W-1:0] backlog_mod;
    } t_result;

    // one resting order held in a cell
    typedef struct packed {
        logic             vld;
        logic [VAL_W-1:0] price;
        logic [VAL_W-1:0] amount;
    } t_entry;

    // command broadcast to every cell of one side, except trim, which reaches the head cell only
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2,
        CMD_TRIM   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [VAL_W-1:0] price;
        logic [VAL_W-1:0] amount;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MATCH = 2'd1,
        ST_REST  = 2'd2,
        ST_OUT   = 2'd3
    } t_state;

    // a before b in book order: bids descending, asks ascending
    function automatic logic ahead(input logic is_ask, input logic [VAL_W-1:0] a,
                                   input logic [VAL_W-1:0] b);
        ahead = is_ask ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

@@ hdl/lobm_cell.sv @@
// ----------------------------------------------------------------------------
// lobm_cell
// one slot of a sorted book; shifts with its neighbors on insert and pop
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_is_ask,
    input  wire lobm_pkg::t_cell_ctl i_ctl,
    input  wire lobm_pkg::t_entry  i_prev,
    input  wire lobm_pkg::t_entry  i_next,
    output lobm_pkg::t_entry       o_entry
);
    import lobm_pkg::*;

    t_entry r_e, n_e;
    logic   w_goes_after_prev, w_new_before_me;

    // position test against incoming price; an empty previous slot means
    // the new order lands further up the chain
    always_comb begin
        w_goes_after_prev = i_prev.vld && !ahead(i_is_ask, i_ctl.price, i_prev.price);
        w_new_before_me   = !r_e.vld || ahead(i_is_ask, i_ctl.price, r_e.price);
    end

    // next slot contents
    always_comb begin
        n_e = r_e;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                if (w_new_before_me) begin
                    if (w_goes_after_prev) begin
                        n_e = '{vld: 1'b1, price: i_ctl.price, amount: i_ctl.amount};
                    end else begin
                        n_e = i_prev;
                    end
                end
            end
            CMD_POP:  n_e = i_next;
            CMD_TRIM: n_e.amount = i_ctl.amount;
            default:  n_e = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.vld <= 1'b0;
        end else begin
            r_e.vld <= n_e.vld;
        end
        r_e.price  <= n_e.price;
        r_e.amount <= n_e.amount;
    end

    assign o_entry = r_e;

endmodule

`default_nettype wire

@@ hdl/lobm_book.sv @@
// ----------------------------------------------------------------------------
// lobm_book
// chain of cells holding one side, best order kept at cell zero
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_book (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_is_ask,
    input  wire lobm_pkg::t_cell_ctl i_ctl,
    output lobm_pkg::t_entry         o_head,
    output logic                     o_full
);
    import lobm_pkg::*;

    t_entry    w_e [BOOK_DEPTH];
    t_entry    w_pv [BOOK_DEPTH];
    t_entry    w_nx [BOOK_DEPTH];
    t_cell_ctl w_cc [BOOK_DEPTH];
    t_entry    w_lead;

    // neighbor wiring: a best-price marker ahead of cell zero, empty after the tail
    always_comb begin
        w_lead = '{vld: 1'b1, price: (i_is_ask ? {VAL_W{1'b0}} : {VAL_W{1'b1}}),
                   amount: {VAL_W{1'b0}}};
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            w_pv[k] = (k == 0) ? w_lead : w_e[(k == 0) ? 0 : k-1];
            w_nx[k] = (k == BOOK_DEPTH-1) ? t_entry'('0)
                                           : w_e[(k == BOOK_DEPTH-1) ? k : k+1];
        end
    end

    // trim only touches the head cell
    always_comb begin
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            w_cc[k] = i_ctl;
            if (k != 0 && i_ctl.cmd == CMD_TRIM) w_cc[k].cmd = CMD_HOLD;
        end
    end

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        lobm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_is_ask(i_is_ask),
            .i_ctl   (w_cc[g]),
            .i_prev  (w_pv[g]),
            .i_next  (w_nx[g]),
            .o_entry (w_e[g])
        );
    end

    assign o_head = w_e[0];
    assign o_full = w_e[BOOK_DEPTH-1].vld;

endmodule

`default_nettype wire

@@ hdl/limit_order_book_matcher_unit.sv @@
// flow: order registered in idle, resting orders popped or trimmed one per match step, result registered in rest
// the next order waits until the result is accepted, so a result stall also holds off the next order
// the sorted cell chains keep the best price at the head, so no search is needed
// result register parts output from input; next order taken once result is out
// synchronous active-low reset empties both books and clears the backlog
`default_nettype none

module limit_order_book_matcher_unit (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire lobm_pkg::t_order i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output lobm_pkg::t_result o_data
);
    import lobm_pkg::*;
    `include "limit_order_book_matcher_unit_macros.svh"

    t_state           r_st, n_st;
    t_order           r_ord;
    logic [VAL_W-1:0] r_rem, r_fill, r_bl;
    t_result          r_res;
    logic             r_ov;

    t_cell_ctl        w_bid_ctl, w_ask_ctl;
    t_entry           w_bid_head, w_ask_head, w_opp;
    logic             w_bid_full, w_ask_full, w_own_full;
    logic             w_cross, w_take;
    logic [VAL_W:0]   w_sub, w_add;
    logic [VAL_W-1:0] w_bl_next;
    logic [VAL_W-1:0] w_fill_m, w_rest_m;

    lobm_book u_bid (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_is_ask(1'b0),
                     .i_ctl(w_bid_ctl), .o_head(w_bid_head), .o_full(w_bid_full));
    lobm_book u_ask (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_is_ask(1'b1),
                     .i_ctl(w_ask_ctl), .o_head(w_ask_head), .o_full(w_ask_full));

    // head of the opposite book and crossing test
    always_comb begin
        w_opp      = r_ord.side ? w_bid_head : w_ask_head;
        w_own_full = r_ord.side ? w_ask_full : w_bid_full;
        w_cross    = w_opp.vld && (r_ord.side ? (w_opp.price >= r_ord.price)
                                              : (w_opp.price <= r_ord.price));
        w_take     = (r_rem >= w_opp.amount);
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (i_valid) n_st = ST_MATCH;
            ST_MATCH: if (r_rem == '0 || !w_cross) n_st = ST_REST;
            ST_REST:  n_st = ST_OUT;
            ST_OUT:   if (!r_ov) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // book commands
    always_comb begin
        w_bid_ctl = '{cmd: CMD_HOLD, price: r_ord.price, amount: r_rem};
        w_ask_ctl = '{cmd: CMD_HOLD, price: r_ord.price, amount: r_rem};
        unique case (r_st)
            ST_MATCH: begin
                if (r_rem != '0 && w_cross) begin
                    if (r_ord.side) begin
                        w_bid_ctl.cmd    = w_take ? CMD_POP : CMD_TRIM;
                        w_bid_ctl.amount = w_opp.amount - r_rem;
                    end else begin
                        w_ask_ctl.cmd    = w_take ? CMD_POP : CMD_TRIM;
                        w_ask_ctl.amount = w_opp.amount - r_rem;
                    end
                end
            end
            ST_REST: begin
                if (r_rem != '0 && !w_own_full) begin
                    if (r_ord.side) w_ask_ctl.cmd = CMD_INSERT;
                    else            w_bid_ctl.cmd = CMD_INSERT;
                end
            end
            default: ;
        endcase
    end

    // backlog update, fill and rest reduced below the modulus first
    always_comb begin
        w_fill_m = (r_fill >= BACKLOG_MOD) ? r_fill - BACKLOG_MOD : r_fill;
        w_rest_m = '0;
        if (r_rem != '0 && !w_own_full)
            w_rest_m = (r_rem >= BACKLOG_MOD) ? r_rem - BACKLOG_MOD : r_rem;
        w_sub = {1'b0, r_bl} + {1'b0, BACKLOG_MOD} - {1'b0, w_fill_m};
        if (w_sub >= {1'b0, BACKLOG_MOD}) w_sub = w_sub - {1'b0, BACKLOG_MOD};
        w_add = w_sub + {1'b0, w_rest_m};
        if (w_add >= {1'b0, BACKLOG_MOD}) w_add = w_add - {1'b0, BACKLOG_MOD};
        w_bl_next = w_add[VAL_W-1:0];
    end

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_bl <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_ord  <= i_data;
                        r_rem  <= i_data.amount;
                        r_fill <= '0;
                    end
                end
                ST_MATCH: begin
                    if (r_rem != '0 && w_cross) begin
                        if (w_take) begin
                            r_rem  <= r_rem - w_opp.amount;
                            r_fill <= r_fill + w_opp.amount;
                        end else begin
                            r_rem  <= '0;
                            r_fill <= r_fill + r_rem;
                        end
                    end
                end
                ST_REST: begin
                    r_bl <= w_bl_next;
                    r_res.filled_amount  <= r_fill;
                    r_res.rested_amount  <= (r_rem != '0 && !w_own_full) ? r_rem : '0;
                    r_res.book_full_drop <= (r_rem != '0 && w_own_full);
                    r_res.backlog_mod    <= w_bl_next;
                    r_ov <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `LOB_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `LOB_ASSERT_NXT(a_rest_out, i_clk, i_rst_n, r_st == ST_REST, o_valid)
    `LOB_ASSERT_IMP(a_bl_range, i_clk, i_rst_n, 1'b1, r_bl < BACKLOG_MOD)

endmodule

`default_nettype wire

@@ dv/lobm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order book result checker
// watches the order and result channels, keeps its own copy of both books
// and compares every result beat field by field with the predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_ord_valid,
    input  wire                i_ord_ready,
    input  wire lobm_pkg::t_order  i_ord,
    input  wire                i_res_valid,
    input  wire                i_res_ready,
    input  wire lobm_pkg::t_result i_res,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_fills,
    output int                 o_drops
);
    import lobm_pkg::*;

    localparam logic SIDE_BUY = 1'b0;

    // shadow books, unordered; best is searched on each match
    logic [VAL_W-1:0] bid_px [BOOK_DEPTH];
    logic [VAL_W-1:0] bid_qty[BOOK_DEPTH];
    logic [VAL_W-1:0] ask_px [BOOK_DEPTH];
    logic [VAL_W-1:0] ask_qty[BOOK_DEPTH];
    int               n_bids;
    int               n_asks;
    longint           backlog;
    t_result          expected_results[$];

    // apply one order to the shadow books and return its result
    function automatic t_result match_order(input t_order ord);
        t_result r;
        logic [VAL_W-1:0] left;
        longint filled;
        int k;
        int i;
        bit is_buy;
        left   = ord.amount;
        filled = 0;
        is_buy = (ord.side == SIDE_BUY);
        r      = '0;
        while (left > 0) begin
            if (is_buy) begin
                if (n_asks == 0) break;
                k = 0;
                for (i = 1; i < n_asks; i++)
                    if (ask_px[i] < ask_px[k]) k = i;
                if (ask_px[k] > ord.price) break;
                if (left >= ask_qty[k]) begin
                    filled += ask_qty[k];
                    left -= ask_qty[k];
                    n_asks--;
                    ask_px[k]  = ask_px[n_asks];
                    ask_qty[k] = ask_qty[n_asks];
                end else begin
                    ask_qty[k] -= left;
                    filled += left;
                    left = 0;
                end
            end else begin
                if (n_bids == 0) break;
                k = 0;
                for (i = 1; i < n_bids; i++)
                    if (bid_px[i] > bid_px[k]) k = i;
                if (bid_px[k] < ord.price) break;
                if (left >= bid_qty[k]) begin
                    filled += bid_qty[k];
                    left -= bid_qty[k];
                    n_bids--;
                    bid_px[k]  = bid_px[n_bids];
                    bid_qty[k] = bid_qty[n_bids];
                end else begin
                    bid_qty[k] -= left;
                    filled += left;
                    left = 0;
                end
            end
        end
        // leftover rests on own side unless that side is full
        if (left > 0) begin
            if (is_buy && n_bids < BOOK_DEPTH) begin
                bid_px[n_bids]  = ord.price;
                bid_qty[n_bids] = left;
                n_bids++;
                r.rested_amount = left;
            end else if (!is_buy && n_asks < BOOK_DEPTH) begin
                ask_px[n_asks]  = ord.price;
                ask_qty[n_asks] = left;
                n_asks++;
                r.rested_amount = left;
            end else begin
                r.book_full_drop = 1'b1;
            end
        end
        backlog = (backlog + 64'd1000000007 - (filled % 64'd1000000007)) % 64'd1000000007;
        backlog = (backlog + r.rested_amount) % 64'd1000000007;
        r.filled_amount = filled[VAL_W-1:0];
        r.backlog_mod   = backlog[VAL_W-1:0];
        return r;
    endfunction

    // predict on order beats, compare on result beats
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            n_bids   = 0;
            n_asks   = 0;
            backlog  = 0;
            o_errors <= 0;
            o_results <= 0;
            o_fills  <= 0;
            o_drops  <= 0;
            expected_results.delete();
        end else begin
            if (i_ord_valid && i_ord_ready)
                expected_results.push_back(match_order(i_ord));
            if (i_res_valid && i_res_ready) begin
                o_results <= o_results + 1;
                if (i_res.filled_amount != 0) o_fills <= o_fills + 1;
                if (i_res.book_full_drop) o_drops <= o_drops + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result beat %h", i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_res) begin
                        if (o_errors < 10)
                            $display("mismatch: exp fill %0d rest %0d drop %0d blog %0d,",
                                     want.filled_amount, want.rested_amount,
                                     want.book_full_drop, want.backlog_mod,
                                     " got fill %0d rest %0d drop %0d blog %0d",
                                     i_res.filled_amount, i_res.rested_amount,
                                     i_res.book_full_drop, i_res.backlog_mod);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order book matcher testbench
// drives directed and random limit orders with random gaps and stalls;
// the checker predicts every result and the top reports the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import lobm_pkg::*;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;
    localparam int   N_RANDOM  = 810;
    localparam int   CYCLE_CAP = 1000000;

    logic    clk;
    logic    rst_n;
    logic    ord_valid;
    logic    ord_ready;
    t_order  ord;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    int      errors;
    int      pending;
    int      results;
    int      fills;
    int      drops;
    int      cycles = 0;
    int      sent;

    limit_order_book_matcher_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (ord_valid),
        .o_ready (ord_ready),
        .i_data  (ord),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res)
    );

    lobm_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_ord_valid (ord_valid),
        .i_ord_ready (ord_ready),
        .i_ord       (ord),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res       (res),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_fills     (fills),
        .o_drops     (drops)
    );

    // clock
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side stalls of random length after accepted beats, with calm stretches
    always @(posedge clk) begin
        int hold;
        if (!rst_n) begin
            res_ready <= 1'b0;
            hold = 0;
        end else if (hold > 0) begin
            hold--;
            res_ready <= 1'b0;
        end else if (res_ready && res_valid) begin
            hold = (sent % 200 < 40) ? 0 : int'($urandom_range(0, 5));
            res_ready <= (hold == 0);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // timeout
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // send one order beat and wait for acceptance; valid stays up when no gap
    task automatic send_order(input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] qty,
                              input logic sd, input int gap);
        if (gap > 0) begin
            ord_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ord_valid <= 1'b1;
        ord       <= '{price: px, amount: qty, side: sd};
        do @(posedge clk); while (!ord_ready);
        sent++;
    endtask

    // random order near a busy price band, sometimes anywhere
    task automatic send_random(input int gap);
        logic [VAL_W-1:0] px;
        logic [VAL_W-1:0] qty;
        if ($urandom_range(0, 9) == 0) px = VAL_W'($urandom());
        else px = VAL_W'(1000 + $urandom_range(0, 40));
        case ($urandom_range(0, 9))
            0:       qty = VAL_W'($urandom());
            1:       qty = 0;
            default: qty = VAL_W'($urandom_range(1, 100));
        endcase
        send_order(px, qty, 1'($urandom_range(0, 1)), gap);
    endtask

    initial begin
        int i;
        int gap;
        sent      = 0;
        rst_n     = 1'b0;
        ord_valid = 1'b0;
        ord       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero amount, ties, partial and full fills
        send_order(30'd0, 30'd0, SIDE_BUY, 0);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_SELL, 0);
        send_order(30'h3FFFFFFF, 30'd5, SIDE_BUY, 1);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY, 0);
        send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL, 0);
        send_order(30'd500, 30'd10, SIDE_BUY, 0);
        send_order(30'd500, 30'd20, SIDE_BUY, 0);
        send_order(30'd500, 30'd15, SIDE_SELL, 2);
        send_order(30'd500, 30'd20, SIDE_SELL, 0);
        send_order(30'd600, 30'd0, SIDE_SELL, 0);
        send_order(30'd600, 30'd7, SIDE_BUY, 0);
        send_order(30'd0, 30'd100, SIDE_SELL, 0);
        send_order(30'h2AAAAAAA, 30'h15555555, SIDE_SELL, 0);
        send_order(30'h15555555, 30'h2AAAAAAA, SIDE_BUY, 0);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY, 0);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY, 0);
        send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL, 0);
        send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL, 0);

        // more bids than the book depth and a sweeping sell, then more asks than the depth and a sweeping buy
        for (i = 0; i < BOOK_DEPTH + 4; i++)
            send_order(VAL_W'(10 + (i % 7)), 30'd1 + i[4:0], SIDE_BUY, 0);
        send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL, 0);
        for (i = 0; i < BOOK_DEPTH + 4; i++)
            send_order(30'h3FFFF000 + VAL_W'(i % 5), 30'd3, SIDE_SELL, 0);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY, 0);

        // random part with occasional gap-free stretches
        for (i = 0; i < N_RANDOM; i++) begin
            gap = (i % 150 < 30) ? 0 : int'($urandom_range(0, 5));
            send_random(gap);
        end
        ord_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("orders sent: %0d, results: %0d, with fills: %0d, dropped leftovers: %0d",
                 sent, results, fills, drops);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/lobm_book.sv
hdl/limit_order_book_matcher_unit.sv
dv/lobm_checker.sv
dv/testbench.sv
